// ===== sv/gcr_pkg.sv =====
// ----------------------------------------------------------------------------
// gcr_pkg: shared types and constants of the glyph column rasterizer
// Holds the register map, the supported font heights and the word that the
// front end hands to the back end through the column queue.
// ----------------------------------------------------------------------------
package gcr_pkg;

  localparam int unsigned CoordW  = 16;
  localparam int unsigned ColorW  = 16;
  localparam int unsigned HeightW = 6;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned CfgIdxW = 2;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] REG_FG_COLOR      = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_BG_COLOR      = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_SCREEN_WIDTH  = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_SCREEN_HEIGHT = 2'd3;

  // Register reset values.
  localparam logic [ColorW-1:0] FG_RESET = 16'h0000;
  localparam logic [ColorW-1:0] BG_RESET = 16'hFFFF;
  localparam logic [CoordW-1:0] SW_RESET = 16'd240;
  localparam logic [CoordW-1:0] SH_RESET = 16'd320;

  // Supported font heights.
  localparam logic [HeightW-1:0] HEIGHT_12 = 6'd12;
  localparam logic [HeightW-1:0] HEIGHT_16 = 6'd16;
  localparam logic [HeightW-1:0] HEIGHT_24 = 6'd24;
  localparam logic [HeightW-1:0] HEIGHT_32 = 6'd32;

  // Column queue depth (two entries, one pointer bit).
  localparam int unsigned QDepth = 2;

  // One drawable glyph byte: origin of its first bit, which bit positions
  // produce a write (MSB first), and which of them are set (foreground).
  typedef struct packed {
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic [ByteW-1:0]  emit;
    logic [ByteW-1:0]  set;
  } col_word_t;

  // Queue status seen by the back end.
  typedef struct packed {
    logic valid;
    logic full;
  } q_status_t;

  function automatic logic height_ok(input logic [HeightW-1:0] h);
    return (h == HEIGHT_12) || (h == HEIGHT_16) || (h == HEIGHT_24) || (h == HEIGHT_32);
  endfunction

endpackage

// ===== sv/gcr_front.sv =====
// ----------------------------------------------------------------------------
// gcr_front: glyph byte classifier
// Tracks the character cursor and turns each glyph byte into a column word
// that lists which of its bits are drawn, then advances the cursor.
// ----------------------------------------------------------------------------
module gcr_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             acc,
  input  logic [gcr_pkg::ByteW-1:0]        glyph_byte,
  input  logic                             first_byte,
  input  logic [gcr_pkg::CoordW-1:0]       start_x,
  input  logic [gcr_pkg::CoordW-1:0]       start_y,
  input  logic [gcr_pkg::HeightW-1:0]      font_height,
  input  logic                             transparent,
  input  logic [gcr_pkg::CoordW-1:0]       screen_width,
  input  logic [gcr_pkg::CoordW-1:0]       screen_height,
  output logic                             push,
  output gcr_pkg::col_word_t               push_word
);

  logic [gcr_pkg::CoordW-1:0]  cx_r, cx_nxt, cy_r, cy_nxt, top_r, top_nxt;
  logic [gcr_pkg::HeightW-1:0] row_r, row_nxt, h_r, h_nxt;
  logic                        tr_r, tr_nxt, stop_r, stop_nxt;

  logic [gcr_pkg::CoordW-1:0]  cx_e, cy_e, top_e;
  logic [gcr_pkg::HeightW-1:0] row_e, h_e, kc;
  logic                        tr_e, stop_e;
  logic [gcr_pkg::CoordW:0]    kb, cx_inc;
  logic                        bottom, col_end;
  logic [3:0]                  k;
  logic [gcr_pkg::ByteW-1:0]   take, emit;

  always_comb begin
    // A first byte loads a new character before its bits are classified.
    if (first_byte) begin
      cx_e   = start_x;
      cy_e   = start_y;
      top_e  = start_y;
      row_e  = '0;
      h_e    = font_height;
      tr_e   = transparent;
      stop_e = !gcr_pkg::height_ok(font_height);
    end else begin
      cx_e   = cx_r;
      cy_e   = cy_r;
      top_e  = top_r;
      row_e  = row_r;
      h_e    = h_r;
      tr_e   = tr_r;
      stop_e = stop_r;
    end

    // Bits left before the bottom edge stops the character (at least one),
    // and bits left before the column ends.
    if (cy_e >= screen_height) begin
      kb = 17'd1;
    end else begin
      kb = {1'b0, screen_height} - {1'b0, cy_e};
    end
    kc = h_e - row_e;

    // The bottom edge wins when both fall on the same bit.
    bottom  = (kb <= 17'd8) && (kb <= {11'b0, kc});
    col_end = !bottom && (kc <= 6'd8);
    if (bottom) begin
      k = kb[3:0];
    end else if (col_end) begin
      k = kc[3:0];
    end else begin
      k = 4'd8;
    end

    take   = ~(8'hFF >> k);
    emit   = take & (glyph_byte | {gcr_pkg::ByteW{!tr_e}});
    cx_inc = {1'b0, cx_e} + 17'd1;

    cx_nxt   = cx_r;
    cy_nxt   = cy_r;
    top_nxt  = top_r;
    row_nxt  = row_r;
    h_nxt    = h_r;
    tr_nxt   = tr_r;
    stop_nxt = stop_r;
    if (acc) begin
      cx_nxt   = cx_e;
      cy_nxt   = cy_e;
      top_nxt  = top_e;
      row_nxt  = row_e;
      h_nxt    = h_e;
      tr_nxt   = tr_e;
      stop_nxt = stop_e;
      if (!stop_e) begin
        if (bottom) begin
          stop_nxt = 1'b1;
        end else if (col_end) begin
          cy_nxt  = top_e;
          row_nxt = '0;
          if (cx_inc >= {1'b0, screen_width}) begin
            stop_nxt = 1'b1;
          end else begin
            cx_nxt = cx_inc[gcr_pkg::CoordW-1:0];
          end
        end else begin
          cy_nxt  = cy_e + 16'd8;
          row_nxt = row_e + 6'd8;
        end
      end
    end

    push           = acc && !stop_e && (emit != '0);
    push_word.x    = cx_e;
    push_word.y    = cy_e;
    push_word.emit = emit;
    push_word.set  = glyph_byte;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r   <= '0;
      cy_r   <= '0;
      top_r  <= '0;
      row_r  <= '0;
      h_r    <= '0;
      tr_r   <= 1'b0;
      stop_r <= 1'b1;
    end else begin
      cx_r   <= cx_nxt;
      cy_r   <= cy_nxt;
      top_r  <= top_nxt;
      row_r  <= row_nxt;
      h_r    <= h_nxt;
      tr_r   <= tr_nxt;
      stop_r <= stop_nxt;
    end
  end

endmodule

// ===== sv/gcr_queue.sv =====
// ----------------------------------------------------------------------------
// gcr_queue: two-entry column word queue
// Decouples the classifier from the pixel emitter.
// ----------------------------------------------------------------------------
module gcr_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  gcr_pkg::col_word_t  push_word,
  input  logic                pop,
  output gcr_pkg::col_word_t  head,
  output gcr_pkg::q_status_t  status
);

  gcr_pkg::col_word_t mem_r [gcr_pkg::QDepth];
  logic               wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [1:0]         cnt_r, cnt_nxt;

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
    head         = mem_r[rd_ptr_r];
    status.valid = (cnt_r != 2'd0);
    status.full  = (cnt_r == 2'd2);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_word;
    end
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// ===== sv/gcr_back.sv =====
// ----------------------------------------------------------------------------
// gcr_back: pixel emitter
// Takes column words from the queue and emits one pixel write per cycle
// into a registered output stage while the output is not stalled.
// ----------------------------------------------------------------------------
module gcr_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  gcr_pkg::col_word_t            head,
  input  gcr_pkg::q_status_t            q_status,
  output logic                          pop,
  input  logic [gcr_pkg::ColorW-1:0]    fg_color,
  input  logic [gcr_pkg::ColorW-1:0]    bg_color,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [gcr_pkg::CoordW-1:0]    out_pixel_x,
  output logic [gcr_pkg::CoordW-1:0]    out_pixel_y,
  output logic [gcr_pkg::ColorW-1:0]    out_pixel_color,
  output logic                          out_last_pixel
);

  logic                      w_valid_r, w_valid_nxt;
  gcr_pkg::col_word_t        w_r, w_nxt;
  logic                      ov_r, ov_nxt;
  logic [gcr_pkg::CoordW-1:0] ox_r, ox_nxt, oy_r, oy_nxt;
  logic [gcr_pkg::ColorW-1:0] oc_r, oc_nxt;
  logic                      ol_r, ol_nxt;

  logic                      out_load, fire, done, found;
  logic [2:0]                idx;
  logic [gcr_pkg::ByteW-1:0] bit_sel, rem;

  always_comb begin
    // Leading drawn bit; position 0 is the MSB, the top row of the run.
    idx   = 3'd0;
    found = 1'b0;
    for (int i = 0; i < 8; i++) begin
      if (!found && w_r.emit[7 - i]) begin
        idx   = 3'(i);
        found = 1'b1;
      end
    end
    bit_sel = 8'h80 >> idx;
    rem     = w_r.emit & ~bit_sel;

    out_load = !ov_r || !out_stall;
    fire     = w_valid_r && out_load;
    done     = fire && (rem == '0);
    pop      = q_status.valid && (!w_valid_r || done);

    w_valid_nxt = w_valid_r;
    w_nxt       = w_r;
    if (pop) begin
      w_valid_nxt = 1'b1;
      w_nxt       = head;
    end else if (done) begin
      w_valid_nxt = 1'b0;
    end else if (fire) begin
      w_nxt.emit = rem;
    end

    ov_nxt = ov_r;
    ox_nxt = ox_r;
    oy_nxt = oy_r;
    oc_nxt = oc_r;
    ol_nxt = ol_r;
    if (fire) begin
      ov_nxt = 1'b1;
      ox_nxt = w_r.x;
      oy_nxt = w_r.y + {13'b0, idx};
      oc_nxt = ((w_r.set & bit_sel) != '0) ? fg_color : bg_color;
      ol_nxt = (rem == '0);
    end else if (out_load) begin
      ov_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    w_r  <= w_nxt;
    ox_r <= ox_nxt;
    oy_r <= oy_nxt;
    oc_r <= oc_nxt;
    ol_r <= ol_nxt;
    if (!rst_n) begin
      w_valid_r <= 1'b0;
      ov_r      <= 1'b0;
    end else begin
      w_valid_r <= w_valid_nxt;
      ov_r      <= ov_nxt;
    end
  end

  assign out_valid       = ov_r;
  assign out_pixel_x     = ox_r;
  assign out_pixel_y     = oy_r;
  assign out_pixel_color = oc_r;
  assign out_last_pixel  = ol_r;

endmodule

// ===== sv/glyph_column_rasterizer.sv =====
// Path: an accepted byte's column word enters the queue, then the emitter's word
// register, then the registered output stage. Throughput: a byte is accepted every
// cycle while the two-word column queue has room; the emitter sends one pixel write
// per cycle unless stalled, up to eight per byte; bytes with no write never reach it.
// Reset (rst_n low, synchronous): registers take their reset values, the queue
// and output stage empty, and no character is active until a first byte.
// ----------------------------------------------------------------------------
// glyph_column_rasterizer: bitmap font character rasterizer
// Turns column-major glyph bytes into pixel writes in foreground or
// background color, stopping a character at the screen edges.
// ----------------------------------------------------------------------------
module glyph_column_rasterizer (
  input  logic                               clk,
  input  logic                               rst_n,
  // Glyph byte channel.
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [gcr_pkg::ByteW-1:0]          in_glyph_byte,
  input  logic                               in_first_byte,
  input  logic [gcr_pkg::CoordW-1:0]         in_start_x,
  input  logic [gcr_pkg::CoordW-1:0]         in_start_y,
  input  logic [gcr_pkg::HeightW-1:0]        in_font_height,
  input  logic                               in_transparent,
  // Pixel write channel.
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [gcr_pkg::CoordW-1:0]         out_pixel_x,
  output logic [gcr_pkg::CoordW-1:0]         out_pixel_y,
  output logic [gcr_pkg::ColorW-1:0]         out_pixel_color,
  output logic                               out_last_pixel,
  // Configuration write channel.
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [gcr_pkg::CfgIdxW-1:0]        cfg_index,
  input  logic [gcr_pkg::ColorW-1:0]         cfg_data
);

  // Configuration registers. Writes are always taken at once.
  logic [gcr_pkg::ColorW-1:0] fg_r, fg_nxt, bg_r, bg_nxt;
  logic [gcr_pkg::CoordW-1:0] sw_r, sw_nxt, sh_r, sh_nxt;

  logic                 in_acc, push, pop;
  gcr_pkg::col_word_t   push_word, head;
  gcr_pkg::q_status_t   q_status;

  assign cfg_ready = 1'b1;

  always_comb begin
    fg_nxt = fg_r;
    bg_nxt = bg_r;
    sw_nxt = sw_r;
    sh_nxt = sh_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        gcr_pkg::REG_FG_COLOR:      fg_nxt = cfg_data;
        gcr_pkg::REG_BG_COLOR:      bg_nxt = cfg_data;
        gcr_pkg::REG_SCREEN_WIDTH:  sw_nxt = cfg_data;
        gcr_pkg::REG_SCREEN_HEIGHT: sh_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fg_r <= gcr_pkg::FG_RESET;
      bg_r <= gcr_pkg::BG_RESET;
      sw_r <= gcr_pkg::SW_RESET;
      sh_r <= gcr_pkg::SH_RESET;
    end else begin
      fg_r <= fg_nxt;
      bg_r <= bg_nxt;
      sw_r <= sw_nxt;
      sh_r <= sh_nxt;
    end
  end

  // The front end only waits for queue space; every byte is classified in
  // the cycle it is accepted, so cursor state is always current.
  assign in_stall = q_status.full;
  assign in_acc   = in_valid && !in_stall;

  gcr_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .acc           (in_acc),
    .glyph_byte    (in_glyph_byte),
    .first_byte    (in_first_byte),
    .start_x       (in_start_x),
    .start_y       (in_start_y),
    .font_height   (in_font_height),
    .transparent   (in_transparent),
    .screen_width  (sw_r),
    .screen_height (sh_r),
    .push          (push),
    .push_word     (push_word)
  );

  gcr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_word (push_word),
    .pop       (pop),
    .head      (head),
    .status    (q_status)
  );

  // The emitter walks the drawn bits of a word, one write per cycle while the
  // output is not stalled, and marks the write for the last drawn bit.
  gcr_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head            (head),
    .q_status        (q_status),
    .pop             (pop),
    .fg_color        (fg_r),
    .bg_color        (bg_r),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_pixel_x     (out_pixel_x),
    .out_pixel_y     (out_pixel_y),
    .out_pixel_color (out_pixel_color),
    .out_last_pixel  (out_last_pixel)
  );

endmodule

// ===== tb/sv/glyph_column_rasterizer_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glyph_column_rasterizer_checker: pixel write predictor and scoreboard
// Watches the glyph byte, pixel write and register channels, rasterizes
// every accepted byte on its own copy of the block state and compares each
// accepted pixel write with the oldest predicted one.
// ----------------------------------------------------------------------------
module glyph_column_rasterizer_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  logic [gcr_pkg::ByteW-1:0]    in_glyph_byte,
  input  logic                         in_first_byte,
  input  logic [gcr_pkg::CoordW-1:0]   in_start_x,
  input  logic [gcr_pkg::CoordW-1:0]   in_start_y,
  input  logic [gcr_pkg::HeightW-1:0]  in_font_height,
  input  logic                         in_transparent,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  logic [gcr_pkg::CoordW-1:0]   out_pixel_x,
  input  logic [gcr_pkg::CoordW-1:0]   out_pixel_y,
  input  logic [gcr_pkg::ColorW-1:0]   out_pixel_color,
  input  logic                         out_last_pixel,
  input  logic                         cfg_valid,
  input  logic                         cfg_ready,
  input  logic [gcr_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [gcr_pkg::ColorW-1:0]   cfg_data,
  output int unsigned                  mismatches,
  output int unsigned                  writes_pending
);
  import gcr_pkg::*;

  typedef struct packed {
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic [ColorW-1:0] color;
    logic              last;
  } pixel_write_t;

  pixel_write_t expected_writes[$];

  logic [ColorW-1:0]  fg_color, bg_color;
  logic [CoordW-1:0]  screen_width, screen_height;
  logic [CoordW-1:0]  cursor_x, cursor_y, top_row;
  logic [HeightW-1:0] char_height;
  logic               char_transparent, char_stopped;

  // Walks the bits of one glyph byte down the current column and queues the
  // pixel writes it should produce.
  task automatic rasterize_byte(input logic [ByteW-1:0] glyph, input logic first,
                                input logic [CoordW-1:0] x0, input logic [CoordW-1:0] y0,
                                input logic [HeightW-1:0] h, input logic transp);
    logic [ByteW-1:0] bits;
    logic [CoordW:0]  next_row, next_col;
    logic             set_bit;
    int               produced;
    pixel_write_t     tail;
    bits = glyph;
    produced = 0;
    if (first) begin
      cursor_x = x0;
      cursor_y = y0;
      top_row = y0;
      char_height = h;
      char_transparent = transp;
      char_stopped = !(h == HEIGHT_12 || h == HEIGHT_16 || h == HEIGHT_24 || h == HEIGHT_32);
    end
    for (int i = 0; i < ByteW && !char_stopped; i++) begin
      set_bit = bits[ByteW-1];
      if (set_bit || !char_transparent) begin
        expected_writes.push_back('{x: cursor_x, y: cursor_y,
                                    color: set_bit ? fg_color : bg_color, last: 1'b0});
        produced++;
      end
      bits = bits << 1;
      next_row = {1'b0, cursor_y} + 17'd1;
      if (next_row >= {1'b0, screen_height}) begin
        char_stopped = 1'b1;
        break;
      end
      cursor_y = next_row[CoordW-1:0];
      if (cursor_y - top_row == {{(CoordW-HeightW){1'b0}}, char_height}) begin
        cursor_y = top_row;
        next_col = {1'b0, cursor_x} + 17'd1;
        if (next_col >= {1'b0, screen_width}) begin
          char_stopped = 1'b1;
          break;
        end
        cursor_x = next_col[CoordW-1:0];
        break;
      end
    end
    if (produced > 0) begin
      tail = expected_writes.pop_back();
      tail.last = 1'b1;
      expected_writes.push_back(tail);
    end
  endtask

  always @(posedge clk) begin
    pixel_write_t want;
    if (!rst_n) begin
      fg_color = FG_RESET;
      bg_color = BG_RESET;
      screen_width = SW_RESET;
      screen_height = SH_RESET;
      cursor_x = '0;
      cursor_y = '0;
      top_row = '0;
      char_height = '0;
      char_transparent = 1'b0;
      char_stopped = 1'b1;
      expected_writes.delete();
      mismatches = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_FG_COLOR:      fg_color = cfg_data;
          REG_BG_COLOR:      bg_color = cfg_data;
          REG_SCREEN_WIDTH:  screen_width = cfg_data;
          REG_SCREEN_HEIGHT: screen_height = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (expected_writes.size() == 0) begin
          $display("%0t: pixel write expected none actual x=%h y=%h color=%h last=%b",
                   $time, out_pixel_x, out_pixel_y, out_pixel_color, out_last_pixel);
          mismatches++;
        end else begin
          want = expected_writes.pop_front();
          if (out_pixel_x !== want.x) begin
            $display("%0t: pixel_x expected %h actual %h", $time, want.x, out_pixel_x);
            mismatches++;
          end
          if (out_pixel_y !== want.y) begin
            $display("%0t: pixel_y expected %h actual %h", $time, want.y, out_pixel_y);
            mismatches++;
          end
          if (out_pixel_color !== want.color) begin
            $display("%0t: pixel_color expected %h actual %h", $time, want.color,
                     out_pixel_color);
            mismatches++;
          end
          if (out_last_pixel !== want.last) begin
            $display("%0t: last_pixel expected %b actual %b", $time, want.last,
                     out_last_pixel);
            mismatches++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        rasterize_byte(in_glyph_byte, in_first_byte, in_start_x, in_start_y,
                       in_font_height, in_transparent);
      end
    end
    writes_pending = expected_writes.size();
  end

endmodule

// ===== tb/sv/glyph_column_rasterizer_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glyph_column_rasterizer_test: stimulus and verdict for the rasterizer
// Feeds hand-picked glyph bytes that hit the edges and special heights, then
// several register settings with random characters, while both channels
// idle at random. A separate checker predicts and compares pixel writes.
// ----------------------------------------------------------------------------
module glyph_column_rasterizer_test;
  import gcr_pkg::*;

  // Cycles without any accepted word before the run is declared hung. The
  // longest honest quiet stretch is a drain plus an idle burst, well below this.
  localparam int unsigned HangLimit = 4000;
  // Random glyph bytes after the directed part.
  localparam int unsigned RandomBytes = 440;
  localparam int unsigned RandomPhases = 6;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic [ByteW-1:0]    in_glyph_byte;
  logic                in_first_byte;
  logic [CoordW-1:0]   in_start_x;
  logic [CoordW-1:0]   in_start_y;
  logic [HeightW-1:0]  in_font_height;
  logic                in_transparent;
  logic                out_valid;
  logic                out_stall;
  logic [CoordW-1:0]   out_pixel_x;
  logic [CoordW-1:0]   out_pixel_y;
  logic [ColorW-1:0]   out_pixel_color;
  logic                out_last_pixel;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [ColorW-1:0]   cfg_data;

  int unsigned mismatches;
  int unsigned writes_pending;
  int unsigned bytes_sent;
  int unsigned quiet_cycles;
  int unsigned stall_left;
  // Set for the closing phase: no idling on either side from then on.
  logic        calm;

  glyph_column_rasterizer uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_glyph_byte   (in_glyph_byte),
    .in_first_byte   (in_first_byte),
    .in_start_x      (in_start_x),
    .in_start_y      (in_start_y),
    .in_font_height  (in_font_height),
    .in_transparent  (in_transparent),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_pixel_x     (out_pixel_x),
    .out_pixel_y     (out_pixel_y),
    .out_pixel_color (out_pixel_color),
    .out_last_pixel  (out_last_pixel),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  glyph_column_rasterizer_checker scoreboard (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_glyph_byte   (in_glyph_byte),
    .in_first_byte   (in_first_byte),
    .in_start_x      (in_start_x),
    .in_start_y      (in_start_y),
    .in_font_height  (in_font_height),
    .in_transparent  (in_transparent),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_pixel_x     (out_pixel_x),
    .out_pixel_y     (out_pixel_y),
    .out_pixel_color (out_pixel_color),
    .out_last_pixel  (out_last_pixel),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .mismatches      (mismatches),
    .writes_pending  (writes_pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // The pixel write receiver stalls now and then in bursts. Between
  // bursts it usually runs free for a while, so long clean stretches occur too.
  initial begin
    out_stall = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (calm) begin
        out_stall <= 1'b0;
      end else if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
        if ($urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 11);
      end
    end
  end

  // Hang detection: any accepted word on any channel resets the count.
  always @(posedge clk) begin
    if (!rst_n) begin
      quiet_cycles <= 0;
    end else if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                 (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= HangLimit) begin
        $display("glyph_column_rasterizer_test: errors");
        $finish;
      end
    end
  end

  // Drops in_valid for an idle burst, its length given by n, before the next glyph byte.
  task automatic hold_input(input int unsigned n);
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  // Presents one glyph byte and waits for the edge that takes it. The valid
  // line stays high on return so back-to-back bytes leave no gap.
  task automatic push_byte(input logic [ByteW-1:0] glyph, input logic first,
                           input logic [CoordW-1:0] x0, input logic [CoordW-1:0] y0,
                           input logic [HeightW-1:0] h, input logic transp);
    if (!calm && $urandom_range(0, 5) == 0) hold_input($urandom_range(1, 11));
    @(negedge clk);
    in_valid       <= 1'b1;
    in_glyph_byte  <= glyph;
    in_first_byte  <= first;
    in_start_x     <= x0;
    in_start_y     <= y0;
    in_font_height <= h;
    in_transparent <= transp;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
  endtask

  // Waits until every predicted pixel write has come out, then waits on
  // so that a byte that draws nothing has left the pipeline as well.
  task automatic drain_pixels();
    @(negedge clk);
    in_valid <= 1'b0;
    while (writes_pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [ColorW-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Register writes only happen with the block idle.
  task automatic set_registers(input logic [ColorW-1:0] fg, input logic [ColorW-1:0] bg,
                               input logic [CoordW-1:0] w, input logic [CoordW-1:0] h);
    drain_pixels();
    write_reg(REG_FG_COLOR, fg);
    write_reg(REG_BG_COLOR, bg);
    write_reg(REG_SCREEN_WIDTH, w);
    write_reg(REG_SCREEN_HEIGHT, h);
  endtask

  // Starting coordinate for a random character: anywhere in the 16-bit range,
  // hugging the far edge, or inside the visible area.
  function automatic logic [CoordW-1:0] pick_origin(input logic [CoordW-1:0] span);
    case ($urandom_range(0, 3))
      0:       return CoordW'($urandom_range(0, 65535));
      1:       return (span > 16'd8) ? span - CoordW'($urandom_range(1, 8)) : '0;
      default: return CoordW'($urandom_range(0, span - 16'd1));
    endcase
  endfunction

  // One character: a first word carrying origin, height and mode, then the
  // remaining glyph words, whose header fields are random and must be ignored.
  task automatic draw_character(input logic [CoordW-1:0] w, input logic [CoordW-1:0] h);
    logic [HeightW-1:0] height;
    int unsigned        per_column, word_count;
    if ($urandom_range(0, 6) == 0) begin
      height = HeightW'($urandom_range(0, 63));
    end else begin
      case ($urandom_range(0, 3))
        0:       height = HEIGHT_12;
        1:       height = HEIGHT_16;
        2:       height = HEIGHT_24;
        default: height = HEIGHT_32;
      endcase
    end
    per_column = (32'(height) + 32'd7) / 32'd8;
    if (per_column == 0) per_column = 1;
    word_count = per_column * $urandom_range(1, 6);
    if ($urandom_range(0, 3) == 0) word_count = $urandom_range(1, word_count);
    push_byte(ByteW'($urandom_range(0, 255)), 1'b1, pick_origin(w), pick_origin(h), height,
              1'($urandom_range(0, 1)));
    for (int k = 1; k < word_count; k++) begin
      push_byte(($urandom_range(0, 7) == 0) ? {ByteW{$urandom_range(0, 1) == 1}}
                                            : ByteW'($urandom_range(0, 255)),
                1'b0, CoordW'($urandom_range(0, 65535)), CoordW'($urandom_range(0, 65535)),
                HeightW'($urandom_range(0, 63)), 1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    logic [CoordW-1:0] scr_w, scr_h;
    logic [ColorW-1:0] fg, bg;
    int unsigned       phase_end, directed_bytes;

    calm           = 1'b0;
    bytes_sent     = 0;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_glyph_byte  = '0;
    in_first_byte  = 1'b0;
    in_start_x     = '0;
    in_start_y     = '0;
    in_font_height = '0;
    in_transparent = 1'b0;
    cfg_valid      = 1'b0;
    cfg_index      = REG_FG_COLOR;
    cfg_data       = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part, running on the reset register values first.
    // Nothing is drawn before any character has started.
    push_byte(8'hFF, 1'b0, 16'd0, 16'd0, HEIGHT_12, 1'b0);
    // Opaque 12-row character: an all-set byte, then an all-clear byte whose last
    // four bits fall past the column and are dropped, then the next column.
    push_byte(8'hFF, 1'b1, 16'd0, 16'd0, HEIGHT_12, 1'b0);
    push_byte(8'h00, 1'b0, 16'd0, 16'd0, HEIGHT_12, 1'b0);
    push_byte(8'hA5, 1'b0, 16'd0, 16'd0, HEIGHT_12, 1'b0);
    push_byte(8'h3C, 1'b0, 16'd0, 16'd0, HEIGHT_12, 1'b0);
    // Transparent character: a clear byte draws nothing, and the mode bit of
    // a later byte does not switch the character back to opaque.
    push_byte(8'h00, 1'b1, 16'd10, 16'd20, HEIGHT_16, 1'b1);
    push_byte(8'h81, 1'b0, 16'd0, 16'd0, HEIGHT_12, 1'b0);
    // Unsupported heights stop the character at once.
    push_byte(8'hFF, 1'b1, 16'd1, 16'd1, 6'd63, 1'b0);
    push_byte(8'hFF, 1'b0, 16'd1, 16'd1, HEIGHT_16, 1'b0);
    push_byte(8'hFF, 1'b1, 16'd1, 16'd1, 6'd0, 1'b0);
    // The two taller heights.
    push_byte(8'h7E, 1'b1, 16'd5, 16'd5, HEIGHT_24, 1'b0);
    push_byte(8'h01, 1'b1, 16'd100, 16'd100, HEIGHT_32, 1'b0);
    // Bottom edge: two rows fit, then the character is stopped for good.
    push_byte(8'hFF, 1'b1, 16'd3, 16'd318, HEIGHT_32, 1'b0);
    push_byte(8'hFF, 1'b0, 16'd3, 16'd318, HEIGHT_32, 1'b0);
    // Right edge: the column in the last screen column completes, then stops.
    push_byte(8'hFF, 1'b1, 16'd239, 16'd0, HEIGHT_12, 1'b0);
    push_byte(8'hFF, 1'b0, 16'd0, 16'd0, HEIGHT_12, 1'b0);
    push_byte(8'hFF, 1'b0, 16'd0, 16'd0, HEIGHT_12, 1'b0);
    // Origin off screen: its own pixel is still written, nothing after it.
    push_byte(8'h80, 1'b1, 16'hFFFF, 16'hFFFF, HEIGHT_16, 1'b0);
    push_byte(8'hFF, 1'b0, 16'd0, 16'd0, HEIGHT_16, 1'b0);
    // Zero screen size stops a character after its first bit.
    set_registers(16'hFFFF, 16'h0000, 16'd0, 16'd0);
    push_byte(8'h55, 1'b1, 16'd0, 16'd0, HEIGHT_12, 1'b0);
    // Largest screen: the bottom edge is reached near the top of the range.
    set_registers(16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    push_byte(8'hFF, 1'b1, 16'hFFFE, 16'hFFFA, HEIGHT_32, 1'b0);
    push_byte(8'h5A, 1'b0, 16'd0, 16'd0, HEIGHT_32, 1'b0);
    push_byte(8'hFF, 1'b1, 16'hFFFE, 16'h0000, HEIGHT_12, 1'b1);
    push_byte(8'h0F, 1'b0, 16'd0, 16'd0, HEIGHT_12, 1'b1);
    directed_bytes = bytes_sent;

    // Random part: several register settings, each carrying a share of
    // random characters with some stray words mixed in. The final phase
    // runs with both sides at full speed.
    for (int phase = 0; phase < RandomPhases; phase++) begin
      if (phase == RandomPhases - 1) calm = 1'b1;
      case ($urandom_range(0, 5))
        0: begin
          scr_w = SW_RESET;
          scr_h = SH_RESET;
        end
        1: begin
          scr_w = CoordW'($urandom_range(1, 40));
          scr_h = CoordW'($urandom_range(1, 40));
        end
        2: begin
          scr_w = 16'hFFFF;
          scr_h = 16'hFFFF;
        end
        3: begin
          scr_w = 16'd1;
          scr_h = 16'd1;
        end
        default: begin
          scr_w = CoordW'($urandom_range(1, 65535));
          scr_h = CoordW'($urandom_range(1, 65535));
        end
      endcase
      fg = ($urandom_range(0, 4) == 0) ? 16'hFFFF : ColorW'($urandom_range(0, 65535));
      bg = ($urandom_range(0, 4) == 0) ? 16'h0000 : ColorW'($urandom_range(0, 65535));
      set_registers(fg, bg, scr_w, scr_h);
      phase_end = directed_bytes + RandomBytes * (phase + 1) / RandomPhases;
      while (bytes_sent < phase_end) begin
        if ($urandom_range(0, 9) == 0) begin
          push_byte(ByteW'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                    CoordW'($urandom_range(0, 65535)), CoordW'($urandom_range(0, 65535)),
                    HeightW'($urandom_range(0, 63)), 1'($urandom_range(0, 1)));
        end else begin
          draw_character(scr_w, scr_h);
        end
      end
    end

    drain_pixels();
    if (mismatches == 0) begin
      $display("glyph_column_rasterizer_test: clean");
    end else begin
      $display("glyph_column_rasterizer_test: errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/gcr_pkg.sv
sv/gcr_front.sv
sv/gcr_queue.sv
sv/gcr_back.sv
sv/glyph_column_rasterizer.sv
tb/sv/glyph_column_rasterizer_checker.sv
tb/sv/glyph_column_rasterizer_test.sv
